### hw/rtl/sob_pkg.sv
// Shared types and constants for the RGB Sobel edge block.
package sob_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int PIX_W      = 24;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);
	localparam logic [15:0]         SAT_LIMIT    = 16'd65280;
	localparam logic [7:0]          EDGE_MAX     = 8'd255;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       flush;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_edge;
		logic [7:0] green_edge;
		logic [7:0] blue_edge;
		logic       frame_end;
	} edge_out_t;

endpackage

### hw/rtl/sobel_edge_rgb.sv
// Top level of the streaming RGB Sobel edge magnitude block.
// Each word is accepted in idle and then passes through the update state for the row
// memory write and window update. Each result then goes through the gradient, squaring,
// bit-serial square root and rounding states and is held on the output until taken.
// Words of the first row give no result. Later, a row end word gives two results, the
// second after a border shift; at width 1 its one result first needs the border shift.
// Words are taken one at a time, and the next word is accepted once the last result
// is taken. The two row memories need no clearing after reset.
module sobel_edge_rgb (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  sob_pkg::pix_in_t         in_word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output sob_pkg::edge_out_t       out_word,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  sob_pkg::cfg_reg_t        cfg_index,
	input  logic [sob_pkg::HEIGHT_W-1:0] cfg_data
);
	import sob_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_UPD    = 8'b0000_0010,
		S_SHIFT0 = 8'b0000_0100,
		S_GRAD   = 8'b0000_1000,
		S_SQR    = 8'b0001_0000,
		S_ROOT   = 8'b0010_0000,
		S_FIN    = 8'b0100_0000,
		S_SEND   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] prev_rd_q, older_rd_q;

	logic [PIX_W-1:0] cur_q;
	logic [COL_W-1:0] addr_q;
	logic top_en_q, mid_en_q, clr_q, e1_q, pend2_q, end_q, sec_q;

	logic [PIX_W-1:0] win_q [9];
	logic [9:0]  ax_q [3];
	logic [9:0]  ay_q [3];
	logic [15:0] s_q [3];
	logic [2:0]  sat_q;
	logic [7:0]  root_q [3];
	logic [2:0]  bit_q;
	edge_out_t   out_q;

	logic [WIDTH_W-1:0]  w_eff, wm1;
	logic [HEIGHT_W-1:0] h_eff;
	logic last, r_out, accept;
	logic [PIX_W-1:0] top_px, mid_px;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == S_SEND);
	assign out_word  = out_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		w_eff = width_q;
		if (width_q == '0) w_eff = WIDTH_W'(1);
		else if (width_q > WIDTH_MAX) w_eff = WIDTH_MAX;
		h_eff = height_q;
		if (height_q == '0) h_eff = HEIGHT_W'(1);
		else if (height_q > HEIGHT_MAX) h_eff = HEIGHT_MAX;
		wm1   = w_eff - WIDTH_W'(1);
		last  = {1'b0, col_q} >= wm1;
		r_out = row_q >= h_eff;
		top_px = top_en_q ? older_rd_q : '0;
		mid_px = mid_en_q ? prev_rd_q : '0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_rd_q  <= prev_mem[col_q];
			older_rd_q <= older_mem[col_q];
		end
		if (state_q == S_UPD) begin
			older_mem[addr_q] <= prev_rd_q;
			prev_mem[addr_q]  <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			col_q    <= '0;
			row_q    <= '0;
			pend2_q  <= 1'b0;
			sec_q    <= 1'b0;
			bit_q    <= '0;
			cur_q    <= '0;
			addr_q   <= '0;
			clr_q    <= 1'b0;
			top_en_q <= 1'b0;
			mid_en_q <= 1'b0;
			e1_q     <= 1'b0;
			end_q    <= 1'b0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q    <= (in_word.flush || r_out) ? '0 :
							{in_word.red_in, in_word.green_in, in_word.blue_in};
						addr_q   <= col_q;
						clr_q    <= (col_q == '0);
						top_en_q <= row_q >= HEIGHT_W'(2);
						mid_en_q <= row_q != '0;
						e1_q     <= (row_q != '0) && (col_q != '0);
						pend2_q  <= (row_q != '0) && last;
						end_q    <= r_out;
						sec_q    <= 1'b0;
						if (last) begin
							col_q <= '0;
							row_q <= r_out ? '0 : row_q + HEIGHT_W'(1);
						end else begin
							col_q <= col_q + COL_W'(1);
						end
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r*3]   <= clr_q ? '0 : win_q[r*3+1];
						win_q[r*3+1] <= clr_q ? '0 : win_q[r*3+2];
					end
					win_q[2] <= top_px;
					win_q[5] <= mid_px;
					win_q[8] <= cur_q;
					if (e1_q) state_q <= S_GRAD;
					else if (pend2_q) state_q <= S_SHIFT0;
					else state_q <= S_IDLE;
				end
				S_SHIFT0: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r*3]   <= win_q[r*3+1];
						win_q[r*3+1] <= win_q[r*3+2];
						win_q[r*3+2] <= '0;
					end
					pend2_q <= 1'b0;
					sec_q   <= 1'b1;
					state_q <= S_GRAD;
				end
				S_GRAD: begin
					state_q <= S_SQR;
				end
				S_SQR: begin
					bit_q   <= 3'd7;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					bit_q <= bit_q - 3'd1;
					if (bit_q == '0) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (out_ready) state_q <= pend2_q ? S_SHIFT0 : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic signed [11:0] gx [3];
	logic signed [11:0] gy [3];
	logic signed [11:0] p [3][9];
	logic [20:0] sum [3];
	logic [7:0]  trial [3];
	logic [15:0] rem [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 9; i++)
				p[k][i] = {4'd0, win_q[i][16-8*k +: 8]};
			gx[k] = p[k][2] - p[k][0] + 12'sd2 * p[k][5] - 12'sd2 * p[k][3]
				+ p[k][8] - p[k][6];
			gy[k] = p[k][6] + 12'sd2 * p[k][7] + p[k][8] - p[k][0]
				- 12'sd2 * p[k][1] - p[k][2];
			sum[k]   = 21'(ax_q[k] * ax_q[k]) + 21'(ay_q[k] * ay_q[k]);
			trial[k] = root_q[k] | (8'd1 << bit_q);
			rem[k]   = s_q[k] - 16'(root_q[k] * root_q[k]);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_GRAD: begin
				for (int k = 0; k < 3; k++) begin
					ax_q[k] <= gx[k][11] ? 10'(-gx[k]) : gx[k][9:0];
					ay_q[k] <= gy[k][11] ? 10'(-gy[k]) : gy[k][9:0];
				end
			end
			S_SQR: begin
				for (int k = 0; k < 3; k++) begin
					sat_q[k]  <= sum[k] > {5'd0, SAT_LIMIT};
					s_q[k]    <= sum[k][15:0];
					root_q[k] <= '0;
				end
			end
			S_ROOT: begin
				for (int k = 0; k < 3; k++)
					if (16'(trial[k] * trial[k]) <= s_q[k]) root_q[k] <= trial[k];
			end
			S_FIN: begin
				out_q.red_edge   <= sat_q[0] ? EDGE_MAX :
					root_q[0] + 8'(rem[0] > {8'd0, root_q[0]});
				out_q.green_edge <= sat_q[1] ? EDGE_MAX :
					root_q[1] + 8'(rem[1] > {8'd0, root_q[1]});
				out_q.blue_edge  <= sat_q[2] ? EDGE_MAX :
					root_q[2] + 8'(rem[2] > {8'd0, root_q[2]});
				out_q.frame_end  <= sec_q && end_q;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while result pending");
	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_UPD) else $error("accept did not update");
	a_end_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.frame_end |-> sec_q) else $error("frame end on first result");
	a_second_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT0 |=> !pend2_q) else $error("second result repeated");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the streaming RGB Sobel edge block.
module testbench;
	import sob_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	pix_in_t   in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	edge_out_t out_word;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_reg_t  cfg_index = REG_WIDTH;
	logic [HEIGHT_W-1:0] cfg_data = '0;

	sobel_edge_rgb i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// edge predictor state
	logic [WIDTH_W-1:0]  width_reg = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	logic [PIX_W-1:0]    line_prev [MAX_WIDTH];
	logic [PIX_W-1:0]    line_older [MAX_WIDTH];
	logic [PIX_W-1:0]    win [9];
	logic [COL_W-1:0]    col_pos = '0;
	logic [HEIGHT_W-1:0] row_pos = '0;

	edge_out_t edge_q [$];
	int        fail_count = 0;
	bit        no_idle = 1'b0;
	bit        pred_on = 1'b1;
	int        out_hold = 0;

	function automatic logic [7:0] root_sat(int gx, int gy);
		int s;
		int n;
		s = gx * gx + gy * gy;
		if (s > int'(SAT_LIMIT))
			return EDGE_MAX;
		n = 0;
		while ((n + 1) * (n + 1) <= s)
			n++;
		if (s - n * n > n)
			n++;
		return (n > 255) ? EDGE_MAX : n[7:0];
	endfunction

	function automatic int ch(int i, int k);
		return int'(win[i][23-8*k -: 8]);
	endfunction

	function automatic edge_out_t window_edge(bit last_px);
		edge_out_t e;
		int gx;
		int gy;
		logic [7:0] m [3];
		for (int k = 0; k < 3; k++) begin
			gx = -ch(0, k) + ch(2, k) - 2 * ch(3, k) + 2 * ch(5, k) - ch(6, k) + ch(8, k);
			gy = -ch(0, k) - 2 * ch(1, k) - ch(2, k) + ch(6, k) + 2 * ch(7, k) + ch(8, k);
			m[k] = root_sat(gx, gy);
		end
		e.red_edge = m[0];
		e.green_edge = m[1];
		e.blue_edge = m[2];
		e.frame_end = last_px;
		return e;
	endfunction

	function automatic void shift_col(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
			logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] cv [3];
		cv[0] = t; cv[1] = m; cv[2] = b;
		for (int r = 0; r < 3; r++) begin
			win[r*3] = win[r*3+1];
			win[r*3+1] = win[r*3+2];
			win[r*3+2] = cv[r];
		end
	endfunction

	function automatic void predict_edges(pix_in_t px);
		int ew;
		int eh;
		int c;
		int r;
		bit last;
		logic [PIX_W-1:0] cur;
		logic [PIX_W-1:0] t;
		logic [PIX_W-1:0] m;
		ew = (width_reg == 0) ? 1 : (width_reg > WIDTH_MAX) ? MAX_WIDTH : int'(width_reg);
		eh = (height_reg == 0) ? 1 : (height_reg > HEIGHT_MAX) ? MAX_HEIGHT : int'(height_reg);
		c = int'(col_pos);
		r = int'(row_pos);
		cur = (px.flush || r >= eh) ? '0 : {px.red_in, px.green_in, px.blue_in};
		t = (r >= 2) ? line_older[c] : '0;
		m = (r >= 1) ? line_prev[c] : '0;
		line_older[c] = line_prev[c];
		line_prev[c] = cur;
		if (c == 0)
			foreach (win[i]) win[i] = '0;
		shift_col(t, m, cur);
		last = (c >= ew - 1);
		if (r >= 1) begin
			if (c >= 1 && pred_on)
				edge_q.push_back(window_edge(1'b0));
			if (last) begin
				shift_col('0, '0, '0);
				if (pred_on)
					edge_q.push_back(window_edge(r >= eh));
			end
		end
		if (last) begin
			col_pos = '0;
			row_pos = (r >= eh) ? '0 : HEIGHT_W'(r + 1);
		end else begin
			col_pos = COL_W'(c + 1);
		end
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (edge_q.size() == 0) begin
				$error("unexpected edge word %h", out_word);
				fail_count++;
			end else begin
				edge_out_t e;
				e = edge_q.pop_front();
				if (out_word.red_edge !== e.red_edge) begin
					$error("red_edge exp %0d got %0d", e.red_edge, out_word.red_edge);
					fail_count++;
				end
				if (out_word.green_edge !== e.green_edge) begin
					$error("green_edge exp %0d got %0d", e.green_edge, out_word.green_edge);
					fail_count++;
				end
				if (out_word.blue_edge !== e.blue_edge) begin
					$error("blue_edge exp %0d got %0d", e.blue_edge, out_word.blue_edge);
					fail_count++;
				end
				if (out_word.frame_end !== e.frame_end) begin
					$error("frame_end exp %0d got %0d", e.frame_end, out_word.frame_end);
					fail_count++;
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			out_hold = $urandom_range(0, 11);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(pix_in_t px);
		int gap;
		gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= px;
		do @(posedge clk); while (!in_ready);
		predict_edges(px);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [HEIGHT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_WIDTH)
			width_reg = val[WIDTH_W-1:0];
		else
			height_reg = val;
	endtask

	task automatic set_size(logic [HEIGHT_W-1:0] w, logic [HEIGHT_W-1:0] h);
		in_valid <= 1'b0;
		wait (edge_q.size() == 0);
		repeat (40) @(posedge clk);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	function automatic pix_in_t rand_pix(bit in_frame);
		pix_in_t px;
		case ($urandom_range(0, 3))
			0: {px.red_in, px.green_in, px.blue_in} = '1;
			1: {px.red_in, px.green_in, px.blue_in} = '0;
			default: {px.red_in, px.green_in, px.blue_in} = 24'($urandom);
		endcase
		px.flush = in_frame ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 9) != 0);
		return px;
	endfunction

	task automatic run_frame(int w, int h);
		int ew;
		int eh;
		ew = (w % 2048 == 0) ? 1 : (w % 2048 > MAX_WIDTH) ? MAX_WIDTH : w % 2048;
		eh = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
		set_size(HEIGHT_W'(w), HEIGHT_W'(h));
		for (int i = 0; i < ew * (eh + 1); i++)
			send_word(rand_pix(i < ew * eh));
	endtask

	typedef struct {
		int        cfg_w;
		int        cfg_h;
		pix_in_t   px;
		int        n_exp;
		edge_out_t e0;
		edge_out_t e1;
	} stim_row_t;

	stim_row_t stim [15];

	initial begin
		int rand_items;
		int w;
		int h;
		foreach (line_prev[i]) begin
			line_prev[i] = '0;
			line_older[i] = '0;
		end
		foreach (win[i]) win[i] = '0;

		stim[0]  = '{0, 0, '{8'hff, 8'hff, 8'hff, 1'b0}, 0, '0, '0};
		stim[1]  = '{-1, 0, '{8'h00, 8'h00, 8'h00, 1'b1}, 1,
			'{8'd0, 8'd0, 8'd0, 1'b1}, '0};
		stim[2]  = '{2, 1, '{8'hff, 8'hff, 8'hff, 1'b0}, 0, '0, '0};
		stim[3]  = '{-1, 0, '{8'hff, 8'hff, 8'hff, 1'b0}, 0, '0, '0};
		stim[4]  = '{-1, 0, '{8'h00, 8'h00, 8'h00, 1'b1}, 0, '0, '0};
		stim[5]  = '{-1, 0, '{8'h00, 8'h00, 8'h00, 1'b1}, 2,
			'{8'd255, 8'd255, 8'd255, 1'b0}, '{8'd255, 8'd255, 8'd255, 1'b1}};
		stim[6]  = '{3, 2, '{8'h12, 8'h80, 8'hff, 1'b0}, -1, '0, '0};
		stim[7]  = '{-1, 0, '{8'hff, 8'h00, 8'h40, 1'b0}, -1, '0, '0};
		stim[8]  = '{-1, 0, '{8'hff, 8'hff, 8'hff, 1'b1}, -1, '0, '0};
		stim[9]  = '{-1, 0, '{8'h00, 8'hff, 8'h01, 1'b0}, -1, '0, '0};
		stim[10] = '{-1, 0, '{8'hab, 8'hcd, 8'hef, 1'b0}, -1, '0, '0};
		stim[11] = '{-1, 0, '{8'h7f, 8'h80, 8'h00, 1'b0}, -1, '0, '0};
		stim[12] = '{-1, 0, '{8'hff, 8'hff, 8'hff, 1'b0}, -1, '0, '0};
		stim[13] = '{-1, 0, '{8'h00, 8'h00, 8'h00, 1'b1}, -1, '0, '0};
		stim[14] = '{-1, 0, '{8'h55, 8'haa, 8'h55, 1'b1}, -1, '0, '0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (stim[i]) begin
			if (stim[i].cfg_w >= 0)
				set_size(HEIGHT_W'(stim[i].cfg_w), HEIGHT_W'(stim[i].cfg_h));
			pred_on = (stim[i].n_exp < 0);
			if (stim[i].n_exp > 0)
				edge_q.push_back(stim[i].e0);
			if (stim[i].n_exp > 1)
				edge_q.push_back(stim[i].e1);
			send_word(stim[i].px);
			pred_on = 1'b1;
		end

		run_frame(6144 + 5, 4);
		run_frame(1, 9);

		rand_items = 0;
		while (rand_items < 1600) begin
			w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
			h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
			if (w == 0 && h == 0)
				h = 3;
			if (w == 0 && $urandom_range(0, 1))
				w = 2048;
			no_idle = (rand_items > 1350);
			run_frame(w, h);
			rand_items += ((w % 2048 == 0) ? 1 : w) * ((h == 0) ? 2 : h + 1);
		end

		in_valid <= 1'b0;
		wait (edge_q.size() == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
